// ===== src/ordered_timer_queue_macros.svh =====
// assertion macros for the ordered timer queue
// expects clk and rst_n in the scope of use
`ifndef ORDERED_TIMER_QUEUE_MACROS_SVH
`define ORDERED_TIMER_QUEUE_MACROS_SVH

// same-cycle implication, disabled in reset
`define OTQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define OTQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/otq_pkg.sv =====
// shared types and constants for the ordered timer queue
// no dependencies
package otq_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int TIME_W = 63;
    localparam int IVAL_W = 32;
    localparam int SEQ_W = 16;
    localparam logic [19:0] MIN_DELAY_RESET = 20'd100;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_TICK = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAN_READ,
        ST_CAN_CHECK,
        ST_SCAN,
        ST_ADD_DONE,
        ST_CAN_DONE,
        ST_EMIT_START,
        ST_EMIT,
        ST_FINAL_START,
        ST_TICK_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_MIN,
        MODE_DUE,
        MODE_RELOAD
    } scan_mode_t;

    typedef struct packed {
        logic [TIME_W-1:0] expiration;
        logic [IVAL_W-1:0] interval;
        logic [SEQ_W-1:0]  sequence_tag;
    } entry_t;

endpackage

// ===== src/otq_arm_delay.sv =====
// arm delay: expiration minus now, floored at zero, clamped to min_delay
// no dependencies
module otq_arm_delay (
    input  logic [62:0] expiration,
    input  logic [62:0] now,
    input  logic [19:0] min_delay,
    output logic [62:0] arm_delay
);

    logic [62:0] diff;

    // difference or zero when already past
    assign diff = (expiration > now) ? (expiration - now) : 63'd0;

    // lower clamp
    assign arm_delay = (diff < {43'd0, min_delay}) ? {43'd0, min_delay} : diff;

endmodule

// ===== src/ordered_timer_queue.sv =====
// ordered timer queue, top level: entry memory, scan sequencer and result register
// depends on otq_pkg, otq_arm_delay and ordered_timer_queue_macros.svh
// add is one scan over the entry memory, cancel a slot read and a scan, tick a scan for
// due timers, one per expired timer plus one, a reload scan and a final scan; one read
// port, one entry a cycle; one item at a time, the next once the result is registered
// reset: asynchronous, clears all valid bits (queue empty) and sets min_delay to 100
`include "ordered_timer_queue_macros.svh"

module ordered_timer_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [3:0]  slot,
    input  logic [15:0] sequence_req,
    input  logic [62:0] expiration,
    input  logic [31:0] interval,
    input  logic [62:0] now,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [3:0]  out_slot,
    output logic [15:0] out_sequence,
    output logic        earliest_changed,
    output logic        cancel_hit,
    output logic [4:0]  expired_count,
    output logic        queue_empty,
    output logic [62:0] next_expiration,
    output logic        arm_request,
    output logic [62:0] arm_delay,
    output logic        last
);

    localparam int S = otq_pkg::SLOTS;
    localparam int IW = otq_pkg::IDX_W;
    localparam int CW = otq_pkg::CNT_W;

    otq_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    otq_pkg::scan_mode_t mode_reg, mode_next;

    logic [1:0]  act_reg, act_next;
    logic [3:0]  slot_reg, slot_next;
    logic [15:0] seq_reg, seq_next;
    logic [62:0] exp_reg, exp_next;
    logic [31:0] ival_reg, ival_next;
    logic [62:0] now_reg, now_next;
    logic [19:0] min_delay_reg;

    logic [S-1:0] valid_reg, valid_next;
    logic [S-1:0] due_reg, due_next;
    logic [S-1:0] left_reg, left_next;
    logic [S-1:0] mask_reg, mask_next;

    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;

    logic          found_reg, found_next;
    logic [62:0]   best_exp_reg, best_exp_next;
    logic [15:0]   best_seq_reg, best_seq_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [4:0]    count_reg, count_next;
    logic          hit_reg, hit_next;

    // entry memory
    otq_pkg::entry_t mem [S];
    otq_pkg::entry_t rd_data_reg, wr_data;
    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;

    // result register
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [3:0]  out_slot_reg;
    logic [15:0] out_seq_reg;
    logic        changed_reg, hit_out_reg, empty_reg, arm_reg, last_reg;
    logic [4:0]  count_out_reg;
    logic [62:0] next_exp_reg, delay_reg;

    logic        load_out;
    logic [1:0]  ld_kind;
    logic [3:0]  ld_slot;
    logic [15:0] ld_seq;
    logic        ld_changed, ld_hit, ld_empty, ld_arm, ld_last;
    logic [4:0]  ld_count;
    logic [62:0] ld_next_exp, ld_delay;

    logic          in_xfer, can_load, scan_issue, scan_done, slot_ok, add_changed;
    logic [IW-1:0] slot_idx;
    logic [S-1:0]  slot_sel, valid_wo_slot;
    logic [62:0]   delay_exp, delay_val;
    logic [63:0]   reload_sum;
    logic [62:0]   reload_exp;

    assign in_xfer = in_valid && in_ready;
    assign can_load = !out_valid_reg || out_ready;
    assign scan_issue = (state_reg == otq_pkg::ST_SCAN) && (scan_cnt_reg != CW'(S));
    assign scan_done = (state_reg == otq_pkg::ST_SCAN) && (scan_cnt_reg == CW'(S))
                       && !rd_pend_reg;
    assign slot_ok = 32'(slot_reg) < S;
    assign slot_idx = IW'(slot_reg);
    assign add_changed = slot_ok && (!found_reg || (exp_reg < best_exp_reg));

    // saturating reload time
    assign reload_sum = {1'b0, now_reg} + {32'd0, rd_data_reg.interval};
    assign reload_exp = reload_sum[63] ? {63{1'b1}} : reload_sum[62:0];

    // arm delay for add or tick results
    assign delay_exp = (act_reg == otq_pkg::ACT_ADD) ? exp_reg : best_exp_reg;

    otq_arm_delay u_delay (
        .expiration(delay_exp),
        .now       (now_reg),
        .min_delay (min_delay_reg),
        .arm_delay (delay_val)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            otq_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (action)
                        otq_pkg::ACT_ADD:    state_next = otq_pkg::ST_SCAN;
                        otq_pkg::ACT_CANCEL: state_next = otq_pkg::ST_CAN_READ;
                        otq_pkg::ACT_TICK:   state_next = otq_pkg::ST_SCAN;
                        default:             state_next = otq_pkg::ST_IDLE;
                    endcase
                end
            end
            otq_pkg::ST_CAN_READ:    state_next = otq_pkg::ST_CAN_CHECK;
            otq_pkg::ST_CAN_CHECK:   state_next = otq_pkg::ST_SCAN;
            otq_pkg::ST_SCAN:        if (scan_done) state_next = ret_reg;
            otq_pkg::ST_EMIT_START:  state_next = otq_pkg::ST_SCAN;
            otq_pkg::ST_FINAL_START: state_next = otq_pkg::ST_SCAN;
            otq_pkg::ST_EMIT:
            begin
                if (!found_reg || can_load)
                    state_next = otq_pkg::ST_SCAN;
            end
            otq_pkg::ST_ADD_DONE,
            otq_pkg::ST_CAN_DONE,
            otq_pkg::ST_TICK_DONE:   if (can_load) state_next = otq_pkg::ST_IDLE;
            default:                 state_next = otq_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        ret_next = ret_reg;
        mode_next = mode_reg;
        act_next = act_reg;
        slot_next = slot_reg;
        seq_next = seq_reg;
        exp_next = exp_reg;
        ival_next = ival_reg;
        now_next = now_reg;
        valid_next = valid_reg;
        due_next = due_reg;
        left_next = left_reg;
        mask_next = mask_reg;
        scan_cnt_next = scan_cnt_reg;
        rd_pend_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        found_next = found_reg;
        best_exp_next = best_exp_reg;
        best_seq_next = best_seq_reg;
        best_idx_next = best_idx_reg;
        count_next = count_reg;
        hit_next = hit_reg;
        rd_en = 1'b0;
        rd_addr = slot_idx;
        wr_en = 1'b0;
        wr_addr = slot_idx;
        wr_data = '{expiration: exp_reg, interval: ival_reg, sequence_tag: seq_reg};
        load_out = 1'b0;
        ld_kind = otq_pkg::KIND_ADD;
        ld_slot = 4'd0;
        ld_seq = 16'd0;
        ld_changed = 1'b0;
        ld_hit = 1'b0;
        ld_empty = 1'b0;
        ld_arm = 1'b0;
        ld_last = 1'b1;
        ld_count = 5'd0;
        ld_next_exp = 63'd0;
        ld_delay = 63'd0;
        slot_sel = (32'(slot) < S) ? ({{(S-1){1'b0}}, 1'b1} << slot) : '0;
        valid_wo_slot = valid_reg & ~slot_sel;

        case (state_reg)
            otq_pkg::ST_IDLE:
            begin
                // capture the item; an add or tick starts its first scan, a cancel first reads its slot
                if (in_xfer)
                begin
                    act_next = action;
                    slot_next = slot;
                    seq_next = sequence_req;
                    exp_next = expiration;
                    ival_next = interval;
                    now_next = now;
                    scan_cnt_next = '0;
                    found_next = 1'b0;
                    count_next = 5'd0;
                    hit_next = 1'b0;
                    mask_next = valid_wo_slot;
                    mode_next = otq_pkg::MODE_MIN;
                    ret_next = otq_pkg::ST_ADD_DONE;
                    if (action == otq_pkg::ACT_TICK)
                    begin
                        mode_next = otq_pkg::MODE_DUE;
                        ret_next = otq_pkg::ST_EMIT_START;
                        due_next = '0;
                        left_next = '0;
                    end
                end
            end
            otq_pkg::ST_CAN_READ:
            begin
                rd_en = 1'b1;
            end
            otq_pkg::ST_CAN_CHECK:
            begin
                // tag match removes the entry, then find the new earliest
                if (slot_ok && valid_reg[slot_idx] && (rd_data_reg.sequence_tag == seq_reg))
                begin
                    hit_next = 1'b1;
                    valid_next[slot_idx] = 1'b0;
                end
                mask_next = valid_next;
                mode_next = otq_pkg::MODE_MIN;
                ret_next = otq_pkg::ST_CAN_DONE;
            end
            otq_pkg::ST_SCAN:
            begin
                // issue one read a cycle
                if (scan_issue)
                begin
                    rd_en = 1'b1;
                    rd_addr = IW'(scan_cnt_reg);
                    rd_pend_next = 1'b1;
                    rd_idx_next = IW'(scan_cnt_reg);
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
                // handle the entry read in the previous cycle
                if (rd_pend_reg)
                begin
                    case (mode_reg)
                        otq_pkg::MODE_MIN:
                        begin
                            if (mask_reg[rd_idx_reg]
                                && (!found_reg || (rd_data_reg.expiration < best_exp_reg)))
                            begin
                                found_next = 1'b1;
                                best_exp_next = rd_data_reg.expiration;
                                best_seq_next = rd_data_reg.sequence_tag;
                                best_idx_next = rd_idx_reg;
                            end
                        end
                        otq_pkg::MODE_DUE:
                        begin
                            if (valid_reg[rd_idx_reg] && (rd_data_reg.expiration <= now_reg))
                            begin
                                due_next[rd_idx_reg] = 1'b1;
                                left_next[rd_idx_reg] = 1'b1;
                            end
                        end
                        otq_pkg::MODE_RELOAD:
                        begin
                            if (due_reg[rd_idx_reg])
                            begin
                                if (rd_data_reg.interval != 32'd0)
                                begin
                                    wr_en = 1'b1;
                                    wr_addr = rd_idx_reg;
                                    wr_data = '{expiration: reload_exp,
                                                interval: rd_data_reg.interval,
                                                sequence_tag: rd_data_reg.sequence_tag};
                                end
                                else
                                begin
                                    valid_next[rd_idx_reg] = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            otq_pkg::ST_EMIT_START:
            begin
                scan_cnt_next = '0;
                found_next = 1'b0;
                mask_next = left_reg;
                mode_next = otq_pkg::MODE_MIN;
                ret_next = otq_pkg::ST_EMIT;
            end
            otq_pkg::ST_EMIT:
            begin
                if (!found_reg)
                begin
                    // all due timers sent, reload or free them
                    scan_cnt_next = '0;
                    mode_next = otq_pkg::MODE_RELOAD;
                    ret_next = otq_pkg::ST_FINAL_START;
                end
                else if (can_load)
                begin
                    load_out = 1'b1;
                    ld_kind = otq_pkg::KIND_EXPIRED;
                    ld_slot = 4'(best_idx_reg);
                    ld_seq = best_seq_reg;
                    ld_last = 1'b0;
                    left_next[best_idx_reg] = 1'b0;
                    mask_next = left_reg & ~({{(S-1){1'b0}}, 1'b1} << best_idx_reg);
                    count_next = count_reg + 5'd1;
                    scan_cnt_next = '0;
                    found_next = 1'b0;
                    mode_next = otq_pkg::MODE_MIN;
                    ret_next = otq_pkg::ST_EMIT;
                end
            end
            otq_pkg::ST_FINAL_START:
            begin
                scan_cnt_next = '0;
                found_next = 1'b0;
                mask_next = valid_reg;
                mode_next = otq_pkg::MODE_MIN;
                ret_next = otq_pkg::ST_TICK_DONE;
            end
            otq_pkg::ST_ADD_DONE:
            begin
                if (can_load)
                begin
                    load_out = 1'b1;
                    ld_kind = otq_pkg::KIND_ADD;
                    ld_slot = slot_reg;
                    ld_changed = add_changed;
                    ld_arm = add_changed;
                    ld_delay = add_changed ? delay_val : 63'd0;
                    ld_empty = slot_ok ? 1'b0 : !found_reg;
                    if (slot_ok)
                        ld_next_exp = add_changed ? exp_reg : best_exp_reg;
                    else
                        ld_next_exp = found_reg ? best_exp_reg : 63'd0;
                    if (slot_ok)
                    begin
                        wr_en = 1'b1;
                        valid_next[slot_idx] = 1'b1;
                    end
                end
            end
            otq_pkg::ST_CAN_DONE:
            begin
                if (can_load)
                begin
                    load_out = 1'b1;
                    ld_kind = otq_pkg::KIND_CANCEL;
                    ld_slot = slot_reg;
                    ld_hit = hit_reg;
                    ld_empty = !found_reg;
                    ld_next_exp = found_reg ? best_exp_reg : 63'd0;
                end
            end
            otq_pkg::ST_TICK_DONE:
            begin
                if (can_load)
                begin
                    load_out = 1'b1;
                    ld_kind = otq_pkg::KIND_TICK;
                    ld_count = count_reg;
                    ld_empty = !found_reg;
                    ld_next_exp = found_reg ? best_exp_reg : 63'd0;
                    ld_arm = found_reg;
                    ld_delay = found_reg ? delay_val : 63'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= otq_pkg::ST_IDLE;
            ret_reg <= otq_pkg::ST_IDLE;
            mode_reg <= otq_pkg::MODE_MIN;
            valid_reg <= '0;
            due_reg <= '0;
            left_reg <= '0;
            scan_cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
            found_reg <= 1'b0;
            count_reg <= 5'd0;
            hit_reg <= 1'b0;
            min_delay_reg <= otq_pkg::MIN_DELAY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            mode_reg <= mode_next;
            valid_reg <= valid_next;
            due_reg <= due_next;
            left_reg <= left_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_pend_reg <= rd_pend_next;
            found_reg <= found_next;
            count_reg <= count_next;
            hit_reg <= hit_next;
            if (cfg_valid && cfg_ready)
                min_delay_reg <= cfg_data;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        slot_reg <= slot_next;
        seq_reg <= seq_next;
        exp_reg <= exp_next;
        ival_reg <= ival_next;
        now_reg <= now_next;
        mask_reg <= mask_next;
        rd_idx_reg <= rd_idx_next;
        best_exp_reg <= best_exp_next;
        best_seq_reg <= best_seq_next;
        best_idx_reg <= best_idx_next;
        if (load_out)
        begin
            kind_reg <= ld_kind;
            out_slot_reg <= ld_slot;
            out_seq_reg <= ld_seq;
            changed_reg <= ld_changed;
            hit_out_reg <= ld_hit;
            count_out_reg <= ld_count;
            empty_reg <= ld_empty;
            next_exp_reg <= ld_next_exp;
            arm_reg <= ld_arm;
            delay_reg <= ld_delay;
            last_reg <= ld_last;
        end
    end

    // entry memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // ports
    assign in_ready = (state_reg == otq_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign out_slot = out_slot_reg;
    assign out_sequence = out_seq_reg;
    assign earliest_changed = changed_reg;
    assign cancel_hit = hit_out_reg;
    assign expired_count = count_out_reg;
    assign queue_empty = empty_reg;
    assign next_expiration = next_exp_reg;
    assign arm_request = arm_reg;
    assign arm_delay = delay_reg;
    assign last = last_reg;

    // checks
    `OTQ_ASSERT_IMP(a_expired_not_last, out_valid && (kind == otq_pkg::KIND_EXPIRED), !last,
        "expired timer result marked last")
    `OTQ_ASSERT_IMP(a_emit_pending, (state_reg == otq_pkg::ST_EMIT) && found_reg,
        left_reg[best_idx_reg] && due_reg[best_idx_reg], "emitting a timer that is not due")
    `OTQ_ASSERT_NXT(a_read_source, rd_en && (state_reg != otq_pkg::ST_SCAN),
        state_reg == otq_pkg::ST_CAN_CHECK, "stray memory read outside scan or cancel")
    `OTQ_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_reg) <= S, "expired count above slot count")

endmodule
